// ===== hw/rtl/ldc_pkg.sv =====
// shared widths, types and the sequencer state encoding for linear_diophantine_count
package ldc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = VALUE_WIDTH + 1;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	// one-hot sequencer states
	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_GCD    = 13'b0000000000010,
		ST_DCHK   = 13'b0000000000100,
		ST_DIVA   = 13'b0000000001000,
		ST_DIVB   = 13'b0000000010000,
		ST_DIVD   = 13'b0000000100000,
		ST_EUC    = 13'b0000001000000,
		ST_EMUL   = 13'b0000010000000,
		ST_DMOD   = 13'b0000100000000,
		ST_YMUL   = 13'b0001000000000,
		ST_QUOT   = 13'b0010000000000,
		ST_FINAL  = 13'b0100000000000,
		ST_OUT    = 13'b1000000000000
	} state_t;

	// commands to the shared divider
	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quot;
		value_t rem;
	} div_rsp_t;

endpackage

// ===== hw/rtl/ldc_divider.sv =====
// restoring divider, one quotient bit per cycle, shared by all divisions of the block
module ldc_divider import ldc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	value_t               quot_q;
	value_t               rem_q;
	value_t               dsor_q;
	logic                 done_q;
	logic [VALUE_WIDTH:0] trial;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BIT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsor_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsor_q}) begin
				rem_q  <= VALUE_WIDTH'(trial - {1'b0, dsor_q});
				quot_q <= {quot_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q  <= trial[VALUE_WIDTH-1:0];
				quot_q <= {quot_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== hw/rtl/linear_diophantine_count.sv =====
// top level: counts nonnegative solutions of a*x + b*y = d
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, weight_a/b, target   | into block
//  out     | out_valid, out_stall, way_count          | out of block
//
// one word at a time
// every division goes through the shared restoring divider;
// gcd and extended euclid need one division per round, up to about 46 rounds,
// and each modular product is a shift-add loop of up to VALUE_WIDTH steps
// reset clears the sequencer and the output valid; no clearing pass
// a finished result waits in its output register while out_stall is high
module linear_diophantine_count import ldc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  value_t weight_a,
	input  value_t weight_b,
	input  value_t target_weight,
	output logic   out_valid,
	input  logic   out_stall,
	output count_t way_count
);

	state_t   state_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic     dbusy_q;      // a division is in flight

	// working registers
	value_t a_q, b_q, d_q;   // operands, later reduced by the gcd
	value_t u_q, v_q;        // euclid remainders
	value_t t0_q, t1_q;      // euclid coefficients modulo a
	value_t mx_q, my_q;      // modular multiplier operands
	value_t acc_q;           // modular multiplier accumulator
	value_t g_q;
	value_t y_q, quot_q;
	count_t count_q;

	logic [VALUE_WIDTH:0] sum_acc;
	logic [VALUE_WIDTH:0] sum_dbl;
	value_t               acc_nxt, dbl_nxt;
	value_t               qt_sub;

	ldc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// shared modular adder pair: acc + x and x + x, both below a
	assign sum_acc = {1'b0, acc_q} + {1'b0, mx_q};
	assign sum_dbl = {1'b0, mx_q} + {1'b0, mx_q};
	assign acc_nxt = (sum_acc >= {1'b0, a_q}) ? VALUE_WIDTH'(sum_acc - {1'b0, a_q})
		: sum_acc[VALUE_WIDTH-1:0];
	assign dbl_nxt = (sum_dbl >= {1'b0, a_q}) ? VALUE_WIDTH'(sum_dbl - {1'b0, a_q})
		: sum_dbl[VALUE_WIDTH-1:0];
	// t0 - q*t1 modulo a
	assign qt_sub = (t0_q >= acc_q) ? (t0_q - acc_q) : (t0_q + (a_q - acc_q));

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign way_count = count_q;

	// divider launch: a start in each division state while the divider is free, operands by state
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '1;
		if (!dbusy_q) begin
			case (state_q)
				ST_GCD: begin
					// a zero weight skips the gcd entirely
					dreq.start    = (v_q != '0) && (a_q != '0);
					dreq.dividend = u_q;
					dreq.divisor  = v_q;
				end
				ST_DCHK: begin
					dreq.start    = 1'b1;
					dreq.dividend = d_q;
					dreq.divisor  = g_q;
				end
				ST_DIVA: begin
					dreq.start    = 1'b1;
					dreq.dividend = a_q;
					dreq.divisor  = g_q;
				end
				ST_DIVB: begin
					dreq.start    = 1'b1;
					dreq.dividend = b_q;
					dreq.divisor  = g_q;
				end
				ST_EUC: begin
					dreq.start    = (v_q != '0);
					dreq.dividend = u_q;
					dreq.divisor  = v_q;
				end
				ST_DMOD: begin
					dreq.start    = 1'b1;
					dreq.dividend = d_q;
					dreq.divisor  = a_q;
				end
				ST_QUOT: begin
					dreq.start    = 1'b1;
					dreq.dividend = d_q;
					dreq.divisor  = b_q;
				end
				ST_FINAL: begin
					dreq.start    = (y_q <= quot_q);
					dreq.dividend = quot_q - y_q;
					dreq.divisor  = a_q;
				end
				default: begin
					dreq.start = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dbusy_q <= 1'b0;
		end else begin
			if (dreq.start)
				dbusy_q <= 1'b1;
			else if (drsp.done)
				dbusy_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (a_q == '0 || b_q == '0)
						state_q <= ST_OUT;
					else if (!dbusy_q && v_q == '0)
						state_q <= ST_DCHK;
				end
				ST_DCHK: begin
					if (drsp.done)
						state_q <= (drsp.rem != '0) ? ST_OUT : ST_DIVA;
				end
				ST_DIVA: begin
					if (drsp.done)
						state_q <= ST_DIVB;
				end
				ST_DIVB: begin
					if (drsp.done)
						state_q <= ST_EUC;
				end
				ST_EUC: begin
					if (!dbusy_q && v_q == '0)
						state_q <= ST_DMOD;
					else if (drsp.done)
						state_q <= ST_EMUL;
				end
				ST_EMUL: begin
					if (my_q == '0)
						state_q <= ST_EUC;
				end
				ST_DMOD: begin
					if (drsp.done)
						state_q <= ST_YMUL;
				end
				ST_YMUL: begin
					if (my_q == '0)
						state_q <= ST_QUOT;
				end
				ST_QUOT: begin
					if (drsp.done)
						state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (!dbusy_q && y_q > quot_q)
						state_q <= ST_OUT;
					else if (drsp.done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q     <= weight_a;
				b_q     <= weight_b;
				d_q     <= target_weight;
				u_q     <= weight_a;
				v_q     <= weight_b;
				count_q <= '0;
			end
			ST_GCD: begin
				// zero weight: gcd path never runs, answer stays 0
				if (!dbusy_q && (a_q == '0 || b_q == '0))
					g_q <= '0;
				else if (!dbusy_q && v_q == '0)
					g_q <= u_q;
				if (drsp.done) begin
					u_q <= v_q;
					v_q <= drsp.rem;
				end
			end
			ST_DCHK: begin
				if (drsp.done)
					d_q <= drsp.quot;
			end
			ST_DIVA: begin
				if (drsp.done)
					a_q <= drsp.quot;
			end
			ST_DIVB: begin
				if (drsp.done) begin
					b_q  <= drsp.quot;
					// euclid on (a, b), tracking the coefficients of b modulo a
					u_q  <= a_q;
					v_q  <= drsp.quot;
					t0_q <= '0;
					t1_q <= (a_q == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
				end
			end
			ST_EUC: begin
				if (drsp.done) begin
					u_q   <= v_q;
					v_q   <= drsp.rem;
					// t1 is doubled modulo a while the bits of q are walked
					mx_q  <= t1_q;
					my_q  <= drsp.quot;
					acc_q <= '0;
				end
			end
			ST_EMUL: begin
				if (my_q != '0) begin
					if (my_q[0])
						acc_q <= acc_nxt;
					mx_q <= dbl_nxt;
					my_q <= my_q >> 1;
				end else begin
					t0_q <= t1_q;
					t1_q <= qt_sub;
				end
			end
			ST_DMOD: begin
				if (drsp.done) begin
					mx_q  <= drsp.rem;
					my_q  <= (t0_q >= a_q) ? '0 : t0_q;
					acc_q <= '0;
				end
			end
			ST_YMUL: begin
				if (my_q != '0) begin
					if (my_q[0])
						acc_q <= acc_nxt;
					mx_q <= dbl_nxt;
					my_q <= my_q >> 1;
				end else begin
					y_q <= acc_q;
				end
			end
			ST_QUOT: begin
				if (drsp.done)
					quot_q <= drsp.quot;
			end
			ST_FINAL: begin
				if (drsp.done)
					count_q <= {1'b0, drsp.quot} + COUNT_WIDTH'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/ldc_checker.sv =====
// port-level assertions for linear_diophantine_count, bound to the top level
module ldc_checker import ldc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_stall,
	input logic   out_valid,
	input logic   out_stall,
	input count_t way_count
);

	// a result stays while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(way_count))
		else $error("result dropped under stall");

	// busy while a result is shown
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("not busy after accept");

	// no result right after an accept
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result without work");

endmodule

bind linear_diophantine_count ldc_checker u_ldc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.way_count (way_count)
);
